@@ design/lru_key_value_cache_macros.svh @@
// Assertion macros used by the cache back end.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define LKV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by a result in the next cycle.
`define LKV_ASSERT_NEXT(name, cond, res, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`endif

@@ design/lkv_pkg.sv @@
// Package with the shared types and constants of the LRU key-value cache.
`default_nettype none
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes carried by a request beat.
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } req_t;

endpackage
`default_nettype wire

@@ design/lkv_if.sv @@
// Channel interfaces of the cache: request, response and configuration.
`default_nettype none

interface lkv_req_if import lkv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [KEY_W-1:0]         key;
  logic signed [VAL_W-1:0]  value;
  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lkv_rsp_if import lkv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [VAL_W-1:0]  read_value;
  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lkv_cfg_if import lkv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CAP_W-1:0]  capacity;
  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

@@ design/lkv_front.sv @@
// Front end: accepts request beats, classifies them and queues them for the back end.
`default_nettype none
module lkv_front import lkv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lkv_req_if.sink    in_ch,
  output req_t       q_item,
  output logic       q_valid,
  input  wire logic  q_pop
);

  localparam int DEPTH = 2;

  req_t                      fifo_r [DEPTH];
  logic                      wr_ptr_r, wr_ptr_nxt;
  logic                      rd_ptr_r, rd_ptr_nxt;
  logic [$clog2(DEPTH+1)-1:0] cnt_r, cnt_nxt;
  logic                      push;
  logic                      pop;
  req_t                      in_item;

  // Classify the incoming beat into a queued request.
  always_comb begin
    in_item.op    = in_ch.kind ? OP_PUT : OP_GET;
    in_item.key   = in_ch.key;
    in_item.value = in_ch.value;
  end

  assign in_ch.ready = (cnt_r != DEPTH[$clog2(DEPTH+1)-1:0]);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_item      = fifo_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

@@ design/lkv_back.sv @@
// Back end: key lookup, recency update, replacement and the response register.
`default_nettype none
`include "lru_key_value_cache_macros.svh"
module lkv_back import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [CAP_W-1:0]  capacity,
  input  wire req_t              q_item,
  input  wire logic              q_valid,
  output logic                   q_pop,
  lkv_rsp_if.source              out_ch
);

  localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = OCC_W + CAP_W;

  typedef enum logic {
    S_LOOK,
    S_EXEC
  } state_t;

  state_t                   state_r, state_nxt;
  logic [MAX_ENTRIES-1:0]   valid_r, valid_nxt;
  logic [RANK_W-1:0]        rank_r [MAX_ENTRIES];
  logic [RANK_W-1:0]        rank_nxt [MAX_ENTRIES];
  logic [OCC_W-1:0]         occ_r, occ_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic [KEY_W-1:0]         key_r [MAX_ENTRIES];
  logic [VAL_W-1:0]         val_r [MAX_ENTRIES];
  req_t                     req_r;
  logic [MAX_ENTRIES-1:0]   match_r, match_nxt;
  logic                     out_hit_r, out_hit_nxt;
  logic [VAL_W-1:0]         out_val_r, out_val_nxt;

  logic                     exec_fire;
  logic                     hit_any;
  logic [RANK_W-1:0]        hit_idx, hit_rank;
  logic [VAL_W-1:0]         hit_val;
  logic [CMP_W-1:0]         cap_x, eff_cap;
  logic                     evict;
  logic [RANK_W-1:0]        oldest_rank;
  logic [MAX_ENTRIES-1:0]   victim;
  logic [RANK_W-1:0]        victim_idx, free_idx, slot_idx;
  logic                     key_we, val_we;
  logic [RANK_W-1:0]        wr_idx;

  assign q_pop     = (state_r == S_LOOK) && q_valid;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  // Parallel key compare against every valid entry.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] && (key_r[i] == q_item.key);
    end
  end

  // Decode the one-hot match into index, rank and stored value.
  always_comb begin
    hit_any  = |match_r;
    hit_idx  = '0;
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match_r[i]) begin
        hit_idx  = hit_idx | RANK_W'(i);
        hit_rank = hit_rank | rank_r[i];
        hit_val  = hit_val | val_r[i];
      end
    end
  end

  // Clamp the capacity register into the range of the entry array.
  always_comb begin
    cap_x = CMP_W'(capacity);
    if (cap_x == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_x > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_x;
    end
    evict = CMP_W'(occ_r) >= eff_cap;
  end

  // Victim is the valid entry with the oldest rank; free slot is the lowest invalid one.
  always_comb begin
    oldest_rank = RANK_W'(occ_r - 1'b1);
    victim_idx  = '0;
    free_idx    = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      victim[i] = valid_r[i] && (rank_r[i] == oldest_rank);
      if (victim[i]) begin
        victim_idx = victim_idx | RANK_W'(i);
      end
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = RANK_W'(i);
      end
    end
    slot_idx = evict ? victim_idx : free_idx;
  end

  // Next state of the directory, the sequencer and the response register.
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    rank_nxt      = rank_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_val_nxt   = out_val_r;
    key_we        = 1'b0;
    val_we        = 1'b0;
    wr_idx        = hit_idx;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOOK: begin
        if (q_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt     = S_LOOK;
          out_valid_nxt = 1'b1;
          out_hit_nxt   = (req_r.op == OP_GET) && hit_any;
          out_val_nxt   = ((req_r.op == OP_GET) && hit_any) ? hit_val : '0;
          if (hit_any) begin
            // Touch the entry: newer valid entries age by one.
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              if (valid_r[i] && (rank_r[i] < hit_rank)) begin
                rank_nxt[i] = rank_r[i] + 1'b1;
              end
            end
            rank_nxt[hit_idx] = '0;
            val_we = (req_r.op == OP_PUT);
          end else if (req_r.op == OP_PUT) begin
            // Insert as most recent, replacing the oldest entry when full.
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              if (valid_r[i] && !(evict && victim[i])) begin
                rank_nxt[i] = rank_r[i] + 1'b1;
              end
            end
            rank_nxt[slot_idx]  = '0;
            valid_nxt[slot_idx] = 1'b1;
            occ_nxt             = evict ? occ_r : occ_r + 1'b1;
            key_we              = 1'b1;
            val_we              = 1'b1;
            wr_idx              = slot_idx;
          end
        end
      end
      default: begin
        state_nxt = S_LOOK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOOK;
      valid_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      rank_r      <= rank_nxt;
    end
  end

  // Payload registers and entry contents carry no reset.
  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
    out_val_r <= out_val_nxt;
    if (q_pop) begin
      req_r   <= q_item;
      match_r <= match_nxt;
    end
    if (key_we) begin
      key_r[wr_idx] <= req_r.key;
    end
    if (val_we) begin
      val_r[wr_idx] <= req_r.value;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.read_value = out_val_r;

  // Consistency checks on the directory and the sequencer.
  `LKV_ASSERT(a_match_unique, (state_r != S_EXEC) || $onehot0(match_r), "two entries hold one key")
  `LKV_ASSERT(a_occ_count, occ_r == OCC_W'($countones(valid_r)), "occupancy out of step with valid bits")
  `LKV_ASSERT(a_occ_bound, occ_r <= OCC_W'(MAX_ENTRIES), "occupancy above entry count")
  `LKV_ASSERT_NEXT(a_look_to_exec, q_pop, state_r == S_EXEC, "popped request not executed")
  `LKV_ASSERT_NEXT(a_exec_done, exec_fire, out_valid_r && (state_r == S_LOOK), "response beat missing")

endmodule
`default_nettype wire

@@ design/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: capacity register, front end and back end.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------
//  in_ch   | in  | valid/ready        | kind, key, value
//  out_ch  | out | valid/ready        | hit, read_value
//  cfg_ch  | in  | valid/ready (=1)   | capacity
//
// Each request passes two back-end states: the parallel key compare in S_LOOK, then
// the recency update, replacement and response write in S_EXEC, before the next request is popped.
// A two-entry queue keeps taking request beats while the back end works or waits.
// The response register holds a result while out_ch.ready is low, which stalls the back end;
// once the queue is full, in_ch.ready drops as well.
// Synchronous active-low reset clears all valid bits, ranks and occupancy.
`default_nettype none
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lkv_req_if.sink    in_ch,
  lkv_rsp_if.source  out_ch,
  lkv_cfg_if.sink    cfg_ch
);

  logic [CAP_W-1:0] capacity_r, capacity_nxt;
  req_t             q_item;
  logic             q_valid;
  logic             q_pop;

  // Capacity register, written on every configuration beat.
  assign cfg_ch.ready = 1'b1;
  assign capacity_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.capacity : capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  lkv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  lkv_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity_r),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

@@ tb/lru_key_value_cache_checker.sv @@
// Checker that mirrors the LRU key-value cache, predicts each response beat and compares it.
module lru_key_value_cache_checker import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic clk,
  input  logic rst_n,
  lkv_req_if   req,
  lkv_rsp_if   rsp,
  lkv_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding
);

  typedef struct {
    logic             hit;
    logic [VAL_W-1:0] read_value;
  } lookup_result_t;

  // Mirror of the cache contents, the recency order and the capacity register.
  logic [KEY_W-1:0] mirror_keys   [MAX_ENTRIES];
  logic [VAL_W-1:0] mirror_values [MAX_ENTRIES];
  logic             mirror_valid  [MAX_ENTRIES];
  int               mirror_rank   [MAX_ENTRIES];
  int               mirror_occupancy;
  logic [CAP_W-1:0] mirror_capacity;

  // Responses predicted for accepted requests, oldest first.
  lookup_result_t expected_lookups [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Prints one line per wrong or unexpected response and counts it.
  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("[%0t] mismatch in %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  // Follow every beat on the three channels at the rising edge.
  always @(posedge clk) begin : mirror_update
    int               slot;
    int               victim;
    int               free_slot;
    int               slot_rank;
    int               limit;
    lookup_result_t   want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        mirror_valid[i] = 1'b0;
        mirror_rank[i]  = 0;
      end
      mirror_occupancy = 0;
      mirror_capacity  = CAP_RESET;
      expected_lookups.delete();
    end else begin
      // A capacity write takes effect for the requests that follow it.
      if (cfg.valid && cfg.ready) begin
        mirror_capacity = cfg.capacity;
      end

      // Compare a response beat with the oldest prediction.
      if (rsp.valid && rsp.ready) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("unexpected response beat", 32'h0, rsp.read_value);
        end else begin
          want = expected_lookups[0];
          expected_lookups.delete(0);
          if (rsp.hit !== want.hit) begin
            report_mismatch("hit", 32'(want.hit), 32'(rsp.hit));
          end
          if (rsp.read_value !== want.read_value) begin
            report_mismatch("read_value", want.read_value, rsp.read_value);
          end
        end
      end

      // Predict the response of a request beat and update the mirror.
      if (req.valid && req.ready) begin
        want.hit        = 1'b0;
        want.read_value = '0;
        slot = -1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (mirror_valid[i] && mirror_keys[i] == req.key) slot = i;
        end

        if (slot >= 0) begin
          // A present key becomes the most recent; newer entries age by one.
          slot_rank = mirror_rank[slot];
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (mirror_valid[i] && mirror_rank[i] < slot_rank) mirror_rank[i]++;
          end
          mirror_rank[slot] = 0;
          if (req.kind == OP_GET) begin
            want.hit        = 1'b1;
            want.read_value = mirror_values[slot];
          end else begin
            mirror_values[slot] = req.value;
          end
        end else if (req.kind == OP_PUT) begin
          // Out-of-range capacities are clamped to the range from one to the array size.
          limit = int'(mirror_capacity);
          if (limit < 1) limit = 1;
          if (limit > MAX_ENTRIES) limit = MAX_ENTRIES;

          // At most one eviction: drop the least recent entry when full.
          if (mirror_occupancy >= limit) begin
            victim = -1;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              if (mirror_valid[i] && (victim < 0 || mirror_rank[i] > mirror_rank[victim]))
                victim = i;
            end
            if (victim >= 0) begin
              mirror_valid[victim] = 1'b0;
              mirror_rank[victim]  = 0;
              if (mirror_occupancy > 0) mirror_occupancy--;
            end
          end

          // Insert into the lowest free slot as the most recent entry.
          free_slot = -1;
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (!mirror_valid[i] && free_slot < 0) free_slot = i;
          end
          if (free_slot >= 0) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              if (mirror_valid[i]) mirror_rank[i]++;
            end
            mirror_keys[free_slot]   = req.key;
            mirror_values[free_slot] = req.value;
            mirror_valid[free_slot]  = 1'b1;
            mirror_rank[free_slot]   = 0;
            mirror_occupancy++;
          end
        end
        expected_lookups.insert(expected_lookups.size(), want);
      end
    end
    outstanding = expected_lookups.size();
  end

endmodule

@@ tb/tb_lru_key_value_cache.sv @@
// Testbench top for the LRU key-value cache: clock, reset, stimulus, stalls and verdict.
module tb_lru_key_value_cache import lkv_pkg::*;;

  localparam int PHASES    = 8;
  localparam int POOL_SIZE = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches;
  int   outstanding;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;

  // Capacity, idle mix, stall mix and request count of each random phase.
  int phase_capacity [PHASES] = '{16, 3, 0, 31, 1, 8, 17, 5};
  int phase_idle     [PHASES] = '{0, 76, 0, 26, 0, 76, 0, 26};
  int phase_stall    [PHASES] = '{0, 0, 76, 26, 0, 0, 76, 26};
  int phase_requests [PHASES] = '{60, 60, 60, 60, 60, 60, 60, 60};

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  lkv_req_if req_ch ();
  lkv_rsp_if rsp_ch ();
  lkv_cfg_if cfg_ch ();

  lru_key_value_cache DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch),
    .cfg_ch (cfg_ch)
  );

  lru_key_value_cache_checker checker_inst (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Response side: stall at random with the current stall rate.
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Sends one request beat, after a random idle gap, and waits for its acceptance.
  task automatic issue_request(op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= op;
    req_ch.key   <= key;
    req_ch.value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the request side idle until every predicted response has arrived.
  task automatic wait_for_responses();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Writes the capacity register with one configuration beat.
  task automatic write_capacity(logic [CAP_W-1:0] capacity);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= capacity;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stimulus: directed checks of eviction and update, then random phases.
  initial begin
    int span;
    op_t op;
    logic [KEY_W-1:0] key;
    req_ch.valid    = 1'b0;
    req_ch.kind     = OP_GET;
    req_ch.key      = '0;
    req_ch.value    = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.capacity = CAP_RESET;
    rsp_ch.ready    = 1'b0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part with room for two entries, so eviction starts early.
    write_capacity(5'd2);
    issue_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);   // miss on an empty cache
    issue_request(OP_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
    issue_request(OP_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
    issue_request(OP_GET, 32'h0000_0000, 32'h1234_5678);   // hit, key zero becomes newest
    issue_request(OP_PUT, 32'h0000_0005, 32'hFFFF_FFFF);   // evicts the all-ones key
    issue_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);   // miss after eviction
    issue_request(OP_GET, 32'h0000_0005, 32'h0000_0000);
    issue_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);   // update of a present key
    issue_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    issue_request(OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);   // evicts key five
    issue_request(OP_GET, 32'h0000_0005, 32'h0000_0000);
    issue_request(OP_GET, 32'hAAAA_AAAA, 32'h0000_0000);
    issue_request(OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA);   // evicts key zero
    issue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    issue_request(OP_GET, 32'h5555_5555, 32'h0000_0000);
    issue_request(OP_PUT, 32'h5555_5555, 32'h8000_0000);
    issue_request(OP_GET, 32'h5555_5555, 32'h7FFF_FFFF);
    issue_request(OP_GET, 32'hAAAA_AAAA, 32'h0000_0000);
    issue_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0001);   // evicts the older of the two
    issue_request(OP_GET, 32'h5555_5555, 32'h0000_0000);
    issue_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);

    // Random phases; the pool keeps most keys repeating so gets hit.
    for (int p = 0; p < PHASES; p++) begin
      wait_for_responses();
      write_capacity(phase_capacity[p][CAP_W-1:0]);
      sender_idle_pct    = phase_idle[p];
      receiver_stall_pct = phase_stall[p];
      span = phase_capacity[p];
      if (span < 1) span = 1;
      if (span > 16) span = 16;
      span = span + 4;
      if (span > POOL_SIZE) span = POOL_SIZE;
      for (int n = 0; n < phase_requests[p]; n++) begin
        op = op_t'($urandom_range(1));
        if ($urandom_range(9) < 8) key = key_pool[$urandom_range(span - 1)];
        else key = $urandom;
        issue_request(op, key, $urandom);
      end
    end

    wait_for_responses();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
